/* rtl/tce_pkg.sv */
`timescale 1ns / 1ps

package tce_pkg;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_ADDC   = 5'd2,
    OP_INC    = 5'd3,
    OP_LOAD   = 5'd4,
    OP_IOREAD = 5'd5,
    OP_STORE  = 5'd6,
    OP_SHL    = 5'd7,
    OP_SHR    = 5'd8,
    OP_AND    = 5'd9,
    OP_OR     = 5'd10,
    OP_XOR    = 5'd11,
    OP_NOT    = 5'd12,
    OP_BEQ    = 5'h0D,
    OP_BIC    = 5'h0E,
    OP_END    = 5'h10
  } op_t;

  typedef struct packed {
    logic c;
    logic z;
    logic v;
    logic n;
  } flags_t;

  typedef struct packed {
    logic [7:0] result;
    flags_t     flags;
    logic [1:0] len;
    logic       taken;
    logic       halt;
    logic       rf_we;
    logic       dm_we;
  } alu_out_t;

  localparam logic [7:0] SignMask = 8'h80;
  localparam logic [7:0] LowMask  = 8'h7F;

endpackage

/* rtl/toy_cpu_execute_unit.sv */
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit first)
// s_*     | in  | mode, first_register, second_register, mem_address, branch_target, io_value
// m_*     | out | result_value, carry_out, zero_out, overflow_out, negative_out,
//         |     | next_pc, branch_taken, halted
//
// one instruction per cycle sustained while m_tready stays high
// input stage reads register file and data memory; execute stage executes and writes back
// a write by the previous instruction is forwarded to the one reading in the same cycle
// rst clears flags, pc, halt and the per-entry valid bits; an entry not yet written reads zero
// a stalled output holds the execute stage and, through it, the input

module toy_cpu_execute_unit import tce_pkg::*; #(
  parameter int MEMORY_DEPTH  = 128,
  parameter int PROGRAM_DEPTH = 64,
  parameter int NUM_REGISTERS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[4:0], first_register[7:5], second_register[10:8], mem_address[17:11],
  // branch_target[23:18], io_value[31:24]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_value[7:0], carry_out[8], zero_out[9], overflow_out[10], negative_out[11],
  // next_pc[17:12], branch_taken[18], halted[19], zero fill[23:20]
  output logic [23:0] m_tdata
);

  localparam int RegAw = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
  localparam int MemAw = $clog2(MEMORY_DEPTH);
  localparam int PcW   = $clog2(PROGRAM_DEPTH);

  // restoring reduction: input below 16 times depth
  function automatic logic [7:0] wrap_mod(input logic [7:0] v, input int unsigned depth);
    logic [11:0] acc;
    logic [11:0] step;
    acc = {4'd0, v};
    for (int k = 3; k >= 0; k--) begin
      step = 12'(depth << k);
      if (acc >= step) begin
        acc = acc - step;
      end
    end
    return acc[7:0];
  endfunction

  function automatic logic [RegAw-1:0] pick_reg(input logic [2:0] idx);
    return ({2'd0, idx} < 5'(NUM_REGISTERS)) ? RegAw'(idx) : '0;
  endfunction

  // input decode
  logic             in_fire;
  logic [RegAw-1:0] in_r1;
  logic [RegAw-1:0] in_r2;
  logic [MemAw-1:0] in_addr;
  logic [PcW-1:0]   in_target;

  assign in_fire   = s_tvalid && s_tready;
  assign in_r1     = pick_reg(s_tdata[7:5]);
  assign in_r2     = pick_reg(s_tdata[10:8]);
  assign in_addr   = MemAw'(wrap_mod({1'b0, s_tdata[17:11]}, MEMORY_DEPTH));
  assign in_target = PcW'(wrap_mod({2'd0, s_tdata[23:18]}, PROGRAM_DEPTH));

  // memories
  logic [7:0]              rf [NUM_REGISTERS];
  logic [NUM_REGISTERS-1:0] rf_valid;
  logic [7:0]              dm [MEMORY_DEPTH];
  logic [MEMORY_DEPTH-1:0] dm_valid;
  logic [7:0]              rf_rd_a;
  logic [7:0]              rf_rd_b;
  logic [7:0]              dm_rd;

  // execute stage
  logic             s1_valid;
  logic [4:0]       s1_mode;
  logic [RegAw-1:0] s1_r1;
  logic [RegAw-1:0] s1_r2;
  logic [MemAw-1:0] s1_addr;
  logic [PcW-1:0]   s1_target;
  logic [7:0]       s1_io;

  // most recent write of each memory, for forwarding
  logic             lw_rf_valid;
  logic [RegAw-1:0] lw_rf_addr;
  logic [7:0]       lw_rf_data;
  logic             lw_dm_valid;
  logic [MemAw-1:0] lw_dm_addr;
  logic [7:0]       lw_dm_data;

  // architectural state
  flags_t         flags;
  logic [PcW-1:0] pc;
  logic           halt_mark;

  logic           out_valid;
  logic [19:0]    out_data;

  logic           s1_fire;
  logic           rf_we;
  logic           dm_we;
  logic [7:0]     op_a;
  logic [7:0]     op_b;
  logic [7:0]     op_mem;
  alu_out_t       alu;
  logic [PcW:0]   pc_sum;
  logic [PcW-1:0] pc_next;

  assign s1_fire  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign rf_we    = s1_fire && !halt_mark && alu.rf_we;
  assign dm_we    = s1_fire && !halt_mark && alu.dm_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[s1_r1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[s1_r1] <= alu.result;
    end
    if (in_fire) begin
      rf_rd_a <= rf_valid[in_r1] ? rf[in_r1] : 8'd0;
      rf_rd_b <= rf_valid[in_r2] ? rf[in_r2] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dm_valid <= '0;
    end else if (dm_we) begin
      dm_valid[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm[s1_addr] <= alu.result;
    end
    if (in_fire) begin
      dm_rd <= dm_valid[in_addr] ? dm[in_addr] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode   <= s_tdata[4:0];
      s1_r1     <= in_r1;
      s1_r2     <= in_r2;
      s1_addr   <= in_addr;
      s1_target <= in_target;
      s1_io     <= s_tdata[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_rf_valid <= 1'b0;
      lw_dm_valid <= 1'b0;
    end else begin
      if (rf_we) begin
        lw_rf_valid <= 1'b1;
      end
      if (dm_we) begin
        lw_dm_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      lw_rf_addr <= s1_r1;
      lw_rf_data <= alu.result;
    end
    if (dm_we) begin
      lw_dm_addr <= s1_addr;
      lw_dm_data <= alu.result;
    end
  end

  // the read happened at the edge of the last write, so it may be stale
  assign op_a   = (lw_rf_valid && lw_rf_addr == s1_r1) ? lw_rf_data : rf_rd_a;
  assign op_b   = (lw_rf_valid && lw_rf_addr == s1_r2) ? lw_rf_data : rf_rd_b;
  assign op_mem = (lw_dm_valid && lw_dm_addr == s1_addr) ? lw_dm_data : dm_rd;

  tce_alu u_alu (
    .mode     (s1_mode),
    .a        (op_a),
    .b        (op_b),
    .mem_data (op_mem),
    .io_data  (s1_io),
    .flags_in (flags),
    .res      (alu)
  );

  assign pc_sum = {1'b0, pc} + (PcW + 1)'(alu.len);

  always_comb begin
    if (alu.taken) begin
      pc_next = s1_target;
    end else if (pc_sum >= (PcW + 1)'(PROGRAM_DEPTH)) begin
      pc_next = PcW'(pc_sum - (PcW + 1)'(PROGRAM_DEPTH));
    end else begin
      pc_next = PcW'(pc_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      pc        <= '0;
      halt_mark <= 1'b0;
    end else if (s1_fire && !halt_mark) begin
      flags     <= alu.flags;
      pc        <= pc_next;
      halt_mark <= alu.halt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (halt_mark) begin
        out_data <= {1'b1, 1'b0, 6'(pc), flags.n, flags.v, flags.z, flags.c, 8'd0};
      end else begin
        out_data <= {alu.halt, alu.taken, 6'(pc_next), alu.flags.n, alu.flags.v,
                     alu.flags.z, alu.flags.c, alu.result};
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_data};

`ifndef SYNTHESIS
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halt_mark |=> halt_mark)
    else $error("halt mark cleared without reset");

  a_halted_no_write: assert property (@(posedge clk) disable iff (rst)
    halt_mark |-> !rf_we && !dm_we)
    else $error("state written while halted");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(rf_we && dm_we))
    else $error("register and memory written by one instruction");

  a_pc_holds: assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> $stable(pc))
    else $error("pc moved without an instruction completing");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input stalled with an empty execute stage");
`endif

endmodule

/* rtl/tce_alu.sv */
`timescale 1ns / 1ps

module tce_alu import tce_pkg::*; (
  input  logic [4:0] mode,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] mem_data,
  input  logic [7:0] io_data,
  input  flags_t     flags_in,
  output alu_out_t   res
);

  logic [7:0] add_b;
  logic       add_cin;
  logic [8:0] sum_full;
  logic [7:0] sum_low;

  always_comb begin
    add_b   = b;
    add_cin = 1'b0;
    if (op_t'(mode) == OP_SUB) begin
      add_b = 8'(~b + 8'd1);
    end else if (op_t'(mode) == OP_ADDC) begin
      add_cin = flags_in.c;
    end
  end

  assign sum_full = {1'b0, a} + {1'b0, add_b} + {8'd0, add_cin};
  // carry into bit 7 comes out of the low seven bits
  assign sum_low  = (a & LowMask) + (add_b & LowMask) + {7'd0, add_cin};

  always_comb begin
    res        = '0;
    res.flags  = flags_in;
    res.len    = 2'd1;
    case (op_t'(mode))
      OP_ADD, OP_SUB, OP_ADDC: begin
        res.result  = sum_full[7:0];
        res.flags.c = sum_full[8];
        res.flags.v = sum_full[8] ^ sum_low[7];
        res.flags.n = (sum_full[7:0] & SignMask) != 8'd0;
        res.flags.z = sum_full[7:0] == 8'd0;
        res.rf_we   = 1'b1;
        res.len     = 2'd3;
      end
      OP_INC: begin
        res.result = 8'(a + 8'd1);
        res.rf_we  = 1'b1;
        res.len    = 2'd2;
      end
      OP_LOAD: begin
        res.result = mem_data;
        res.rf_we  = 1'b1;
        res.len    = 2'd3;
      end
      OP_IOREAD: begin
        res.result = io_data;
        res.rf_we  = 1'b1;
        res.len    = 2'd2;
      end
      OP_STORE: begin
        res.result = a;
        res.dm_we  = 1'b1;
        res.len    = 2'd3;
      end
      OP_SHL: begin
        res.result = {a[6:0], 1'b0};
        res.rf_we  = 1'b1;
        res.len    = 2'd2;
      end
      OP_SHR: begin
        res.result = {1'b0, a[7:1]};
        res.rf_we  = 1'b1;
        res.len    = 2'd2;
      end
      OP_AND: begin
        res.result = a & b;
        res.rf_we  = 1'b1;
        res.len    = 2'd3;
      end
      OP_OR: begin
        res.result = a | b;
        res.rf_we  = 1'b1;
        res.len    = 2'd3;
      end
      OP_XOR: begin
        res.result = a ^ b;
        res.rf_we  = 1'b1;
        res.len    = 2'd3;
      end
      OP_NOT: begin
        res.result = ~a;
        res.rf_we  = 1'b1;
        res.len    = 2'd2;
      end
      OP_BEQ: begin
        res.taken = flags_in.z;
        res.len   = 2'd2;
      end
      OP_BIC: begin
        res.taken = flags_in.c;
        res.len   = 2'd2;
      end
      OP_END: begin
        res.halt = 1'b1;
      end
      default: begin
        res.len = 2'd1;
      end
    endcase
  end

endmodule
